@@ hdl/dmd_pkg.sv @@
// Shared types, codes and arithmetic helpers for the dual motor drive block.
// Used by dmd_state, dmd_duty and dual_motor_drive_with_pulse_rate_top.
`default_nettype none

package dmd_pkg;

  // Event codes carried in the func field of an input transaction.
  typedef enum logic [2:0] {
    FUNC_SET   = 3'd0,
    FUNC_STOP  = 3'd1,
    FUNC_ESTOP = 3'd2,
    FUNC_PULSE = 3'd3,
    FUNC_TICK  = 3'd4
  } func_t;

  // Configuration register indexes.
  localparam logic CFG_MIN_DUTY = 1'b0;
  localparam logic CFG_PERIOD   = 1'b1;

  localparam logic [7:0]  FULL_DUTY      = 8'd255;
  localparam logic [6:0]  PCT_MAX        = 7'd100;
  localparam logic [6:0]  MIN_DUTY_RST   = 7'd20;
  localparam logic [15:0] PERIOD_RST     = 16'd1000;
  localparam logic [15:0] ELAPSED_MAX    = 16'hFFFF;
  localparam logic [1:0]  ID_MOTOR1      = 2'd1;
  localparam logic [1:0]  ID_MOTOR2      = 2'd2;
  localparam logic [1:0]  ID_BOTH        = 2'd0;
  // x / 100 == (x * 5243) >> 19 for every x up to 25500.
  localparam logic [12:0] RECIP_100      = 13'd5243;
  localparam int          RECIP_SHIFT    = 19;

  // One input transaction, last field in the lowest bits.
  typedef struct packed {
    logic       forward;
    logic [7:0] speed_percent;
    logic [1:0] motor_id;
    logic [2:0] func;
  } item_t;

  // One result transaction, last field in the lowest bits.
  typedef struct packed {
    logic        status;
    logic [31:0] m2_rate;
    logic [31:0] m1_rate;
    logic [6:0]  m2_speed;
    logic        m2_reverse;
    logic        m2_run;
    logic [7:0]  m2_duty;
    logic [6:0]  m1_speed;
    logic        m1_reverse;
    logic        m1_run;
    logic [7:0]  m1_duty;
  } result_t;

  // Motor and tach state after one event, everything except the duty.
  typedef struct packed {
    logic [1:0][6:0]  speed;
    logic [1:0]       run;
    logic [1:0]       reverse;
    logic [1:0][31:0] rate;
    logic             status;
  } snap_t;

  // Duty update requested by one event.
  typedef struct packed {
    logic       set;
    logic       mot;
    logic [1:0] zero;
    logic [6:0] speed;
  } duty_req_t;

  // Quotient by 100 for values up to 25500, by reciprocal multiplication.
  function automatic logic [7:0] div100(input logic [14:0] x);
    logic [27:0] prod;
    prod = 28'(x) * 28'(RECIP_100);
    return prod[RECIP_SHIFT+7:RECIP_SHIFT];
  endfunction

  // Lowest nonzero duty, 255 * pct / 100, with pct clamped to 100.
  function automatic logic [7:0] floor_for(input logic [6:0] pct_raw);
    logic [6:0]  pct;
    logic [14:0] x;
    pct = (pct_raw > PCT_MAX) ? PCT_MAX : pct_raw;
    x   = {pct, 8'd0} - 15'(pct);
    return div100(x);
  endfunction

endpackage

`default_nettype wire

@@ hdl/dmd_state.sv @@
// Motor command and tach state: applies one event and registers the snapshot.
// Depends on dmd_pkg.
`default_nettype none

module dmd_state (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               en,
  input  wire dmd_pkg::item_t     item,
  input  wire logic               period_we,
  input  wire logic [15:0]        period_wdata,
  output dmd_pkg::duty_req_t      req,
  output dmd_pkg::snap_t          snap_r
);

  logic [1:0][6:0]  speed_r, speed_nxt;
  logic [1:0]       run_r, run_nxt;
  logic [1:0]       rev_r, rev_nxt;
  logic [1:0][31:0] total_r, total_nxt;
  logic [1:0][31:0] base_r, base_nxt;
  logic [1:0][31:0] rate_r, rate_nxt;
  logic [15:0]      elapsed_r, elapsed_nxt;
  logic [15:0]      period_r;
  logic             status_nxt;

  always_comb begin
    logic       valid;
    logic       m;
    logic [6:0] sp;
    logic [15:0] e;
    valid       = (item.motor_id == dmd_pkg::ID_MOTOR1) ||
                  (item.motor_id == dmd_pkg::ID_MOTOR2);
    m           = (item.motor_id == dmd_pkg::ID_MOTOR2);
    sp          = (item.speed_percent > 8'(dmd_pkg::PCT_MAX)) ? dmd_pkg::PCT_MAX
                                                              : item.speed_percent[6:0];
    e           = (elapsed_r != dmd_pkg::ELAPSED_MAX) ? elapsed_r + 16'd1 : elapsed_r;
    speed_nxt   = speed_r;
    run_nxt     = run_r;
    rev_nxt     = rev_r;
    total_nxt   = total_r;
    base_nxt    = base_r;
    rate_nxt    = rate_r;
    elapsed_nxt = elapsed_r;
    status_nxt  = 1'b0;
    req         = '0;
    case (item.func)
      dmd_pkg::FUNC_SET: begin
        if (!valid) begin
          status_nxt = 1'b1;
        end else begin
          speed_nxt[m] = sp;
          if (sp == 7'd0) begin
            run_nxt[m]  = 1'b0;
            req.zero[m] = 1'b1;
          end else begin
            rev_nxt[m] = ~item.forward;
            run_nxt[m] = 1'b1;
            req.set    = 1'b1;
            req.mot    = m;
            req.speed  = sp;
          end
        end
      end
      dmd_pkg::FUNC_STOP: begin
        if (item.motor_id == dmd_pkg::ID_BOTH) begin
          speed_nxt = '0;
          run_nxt   = '0;
          req.zero  = 2'b11;
        end else if (valid) begin
          speed_nxt[m] = 7'd0;
          run_nxt[m]   = 1'b0;
          req.zero[m]  = 1'b1;
        end else begin
          status_nxt = 1'b1;
        end
      end
      dmd_pkg::FUNC_ESTOP: begin
        speed_nxt = '0;
        run_nxt   = '0;
        req.zero  = 2'b11;
      end
      dmd_pkg::FUNC_PULSE: begin
        if (valid) begin
          total_nxt[m] = total_r[m] + 32'd1;
        end else begin
          status_nxt = 1'b1;
        end
      end
      dmd_pkg::FUNC_TICK: begin
        if (e >= period_r) begin
          rate_nxt[0] = total_r[0] - base_r[0];
          rate_nxt[1] = total_r[1] - base_r[1];
          base_nxt    = total_r;
          elapsed_nxt = 16'd0;
        end else begin
          elapsed_nxt = e;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speed_r   <= '0;
      run_r     <= '0;
      rev_r     <= '0;
      total_r   <= '0;
      base_r    <= '0;
      rate_r    <= '0;
      elapsed_r <= '0;
      period_r  <= dmd_pkg::PERIOD_RST;
    end else begin
      if (period_we) begin
        period_r <= period_wdata;
      end
      if (en) begin
        speed_r   <= speed_nxt;
        run_r     <= run_nxt;
        rev_r     <= rev_nxt;
        total_r   <= total_nxt;
        base_r    <= base_nxt;
        rate_r    <= rate_nxt;
        elapsed_r <= elapsed_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      snap_r.speed   <= speed_nxt;
      snap_r.run     <= run_nxt;
      snap_r.reverse <= rev_nxt;
      snap_r.rate    <= rate_nxt;
      snap_r.status  <= status_nxt;
    end
  end

endmodule

`default_nettype wire

@@ hdl/dmd_duty.sv @@
// Duty pipeline: speed times span, division by 100, and the per-motor duty store.
// Depends on dmd_pkg.
`default_nettype none

module dmd_duty (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               min_duty_we,
  input  wire logic [6:0]         min_duty_wdata,
  input  wire logic               en1,
  input  wire logic               en2,
  input  wire logic               en_out,
  input  wire dmd_pkg::duty_req_t req,
  output logic [1:0][7:0]         duty_nxt
);

  logic [7:0]       floor_r;
  logic [7:0]       span;
  logic [14:0]      prod1_r;
  logic             set1_r, mot1_r;
  logic [1:0]       zero1_r;
  logic [7:0]       quo2_r;
  logic             set2_r, mot2_r;
  logic [1:0]       zero2_r;
  logic [1:0][7:0]  duty_r;

  // The floor is kept already scaled, so an item only sees one product.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      floor_r <= dmd_pkg::floor_for(dmd_pkg::MIN_DUTY_RST);
    end else if (min_duty_we) begin
      floor_r <= dmd_pkg::floor_for(min_duty_wdata);
    end
  end

  assign span = dmd_pkg::FULL_DUTY - floor_r;

  always_ff @(posedge clk) begin
    if (en1) begin
      prod1_r <= 15'(req.speed) * 15'(span);
      set1_r  <= req.set;
      mot1_r  <= req.mot;
      zero1_r <= req.zero;
    end
    if (en2) begin
      quo2_r  <= dmd_pkg::div100(prod1_r);
      set2_r  <= set1_r;
      mot2_r  <= mot1_r;
      zero2_r <= zero1_r;
    end
  end

  always_comb begin
    for (int k = 0; k < 2; k++) begin
      duty_nxt[k] = duty_r[k];
      if (zero2_r[k]) begin
        duty_nxt[k] = 8'd0;
      end
      if (set2_r && (mot2_r == 1'(k))) begin
        duty_nxt[k] = floor_r + quo2_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      duty_r <= '0;
    end else if (en_out) begin
      duty_r <= duty_nxt;
    end
  end

endmodule

`default_nettype wire

@@ hdl/dual_motor_drive_with_pulse_rate_top.sv @@
// Top level of the dual motor drive block with tach pulse rate measurement.
// Depends on dmd_pkg, dmd_state and dmd_duty.
`default_nettype none

// Each input transaction is one event: set motor, stop, emergency stop, tach
// pulse or millisecond tick. Every event yields exactly one result transaction
// with both motors' duty, enable, direction pin and stored speed, the two
// pulse rates and a status bit that flags an invalid motor id. The block takes
// one event per clock cycle while the result side keeps up, and each result is
// offered once its event has passed four registers: an input register, the
// state update stage (which also forms speed times duty span), the
// divide-by-100 stage, and the output register where the duty store is
// updated. Stages advance independently, so a stall on the result side only
// blocks the input once every stage holds an event. The duty floor is
// recomputed when min_duty_percent is written, and both configuration
// registers must be written only while no event is in flight. Duty for a
// nonzero speed is floor + speed * (255 - floor) / 100, with floor =
// 255 * min(min_duty_percent, 100) / 100; a zero speed, a stop or an
// emergency stop clears duty and enable but leaves the direction pin alone.

module dual_motor_drive_with_pulse_rate_top (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_tvalid,
  output logic               in_tready,
  // func[2:0], motor_id[4:3], speed_percent[12:5], forward[13], zero[15:14]
  input  wire logic [15:0]   in_tdata,
  output logic               out_tvalid,
  input  wire logic          out_tready,
  // m1_duty[7:0], m1_run[8], m1_reverse[9], m1_speed[16:10], m2_duty[24:17],
  // m2_run[25], m2_reverse[26], m2_speed[33:27], m1_rate[65:34],
  // m2_rate[97:66], status[98], zero[103:99]
  output logic [103:0]       out_tdata,
  input  wire logic          cfg_we,
  input  wire logic          cfg_addr,
  input  wire logic [15:0]   cfg_wdata
);

  logic                v0_r, v1_r, v2_r, vo_r;
  logic                free0, free1, free2, ready_o;
  logic                en1, en2, en_o;
  dmd_pkg::item_t      item_r;
  dmd_pkg::snap_t      snap1;
  dmd_pkg::snap_t      snap2_r;
  dmd_pkg::duty_req_t  req;
  logic [1:0][7:0]     duty_nxt;
  dmd_pkg::result_t    res_nxt, res_r;
  logic                min_duty_we, period_we;

  // Each stage may take a new transaction when it is empty or moving on.
  assign ready_o   = !vo_r || out_tready;
  assign free2     = !v2_r || ready_o;
  assign free1     = !v1_r || free2;
  assign free0     = !v0_r || free1;
  assign in_tready = free0;
  assign en1       = v0_r && free1;
  assign en2       = v1_r && free2;
  assign en_o      = v2_r && ready_o;

  assign min_duty_we = cfg_we && (cfg_addr == dmd_pkg::CFG_MIN_DUTY);
  assign period_we   = cfg_we && (cfg_addr == dmd_pkg::CFG_PERIOD);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      vo_r <= 1'b0;
    end else begin
      if (free0) begin
        v0_r <= in_tvalid;
      end
      if (free1) begin
        v1_r <= v0_r;
      end
      if (free2) begin
        v2_r <= v1_r;
      end
      if (ready_o) begin
        vo_r <= v2_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (free0 && in_tvalid) begin
      item_r <= dmd_pkg::item_t'(in_tdata[13:0]);
    end
    if (en2) begin
      snap2_r <= snap1;
    end
    if (en_o) begin
      res_r <= res_nxt;
    end
  end

  dmd_state u_state (
    .clk          (clk),
    .rst_n        (rst_n),
    .en           (en1),
    .item         (item_r),
    .period_we    (period_we),
    .period_wdata (cfg_wdata),
    .req          (req),
    .snap_r       (snap1)
  );

  dmd_duty u_duty (
    .clk            (clk),
    .rst_n          (rst_n),
    .min_duty_we    (min_duty_we),
    .min_duty_wdata (cfg_wdata[6:0]),
    .en1            (en1),
    .en2            (en2),
    .en_out         (en_o),
    .req            (req),
    .duty_nxt       (duty_nxt)
  );

  always_comb begin
    res_nxt.m1_duty    = duty_nxt[0];
    res_nxt.m1_run     = snap2_r.run[0];
    res_nxt.m1_reverse = snap2_r.reverse[0];
    res_nxt.m1_speed   = snap2_r.speed[0];
    res_nxt.m2_duty    = duty_nxt[1];
    res_nxt.m2_run     = snap2_r.run[1];
    res_nxt.m2_reverse = snap2_r.reverse[1];
    res_nxt.m2_speed   = snap2_r.speed[1];
    res_nxt.m1_rate    = snap2_r.rate[0];
    res_nxt.m2_rate    = snap2_r.rate[1];
    res_nxt.status     = snap2_r.status;
  end

  assign out_tvalid = vo_r;
  assign out_tdata  = {5'd0, res_r};

  // With the output register empty, every stage is free to move.
  a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
    !vo_r |-> in_tready)
    else $error("input stalled while output register empty");

  // A blocked middle stage keeps its transaction.
  a_stage1_held: assert property (@(posedge clk) disable iff (!rst_n)
    (v1_r && !free2) |=> v1_r)
    else $error("stage 1 transaction lost under stall");

  // Duty pipeline and state update agree: a running motor has nonzero duty.
  a_m1_duty_run: assert property (@(posedge clk) disable iff (!rst_n)
    vo_r |-> (res_r.m1_run == (res_r.m1_duty != 8'd0)))
    else $error("motor 1 duty and enable disagree");

  a_m2_duty_run: assert property (@(posedge clk) disable iff (!rst_n)
    vo_r |-> (res_r.m2_run == (res_r.m2_duty != 8'd0)))
    else $error("motor 2 duty and enable disagree");

  // A motor runs exactly when its stored speed is nonzero.
  a_run_speed: assert property (@(posedge clk) disable iff (!rst_n)
    vo_r |-> ((res_r.m1_run == (res_r.m1_speed != 7'd0)) &&
              (res_r.m2_run == (res_r.m2_speed != 7'd0))))
    else $error("enable and stored speed disagree");

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
// Self-checking testbench for dual_motor_drive_with_pulse_rate_top.
// Holds its own model of both motors and the tach counters in a small scoreboard class.
// Depends only on dmd_pkg and the top level of the block.

import dmd_pkg::*;

class motor_board;
  // Configuration as last written.
  logic [6:0]  min_pct;
  logic [15:0] period;
  // Motor state, index 0 is motor 1.
  logic [6:0]  speed_now[2];
  logic        ahead[2];
  logic        rev_pin[2];
  logic [7:0]  duty_now[2];
  logic        run_now[2];
  // Tach counters and rates.
  logic [31:0] pulse_cnt[2];
  logic [31:0] pulse_mark[2];
  logic [31:0] rate_now[2];
  logic [15:0] ms_count;
  // Predicted result transactions, oldest first.
  result_t     awaited_states[$];
  int          errors;

  function new();
    min_pct  = MIN_DUTY_RST;
    period   = PERIOD_RST;
    ms_count = '0;
    errors   = 0;
    for (int k = 0; k < 2; k++) begin
      speed_now[k]  = '0;
      ahead[k]      = 1'b1;
      rev_pin[k]    = 1'b0;
      duty_now[k]   = '0;
      run_now[k]    = 1'b0;
      pulse_cnt[k]  = '0;
      pulse_mark[k] = '0;
      rate_now[k]   = '0;
    end
  endfunction

  function void write_reg(logic addr, logic [15:0] data);
    if (addr == CFG_MIN_DUTY) min_pct = data[6:0];
    else period = data;
  endfunction

  // Stores speed and direction. A nonzero speed also sets the direction pin,
  // the duty and the enable; a zero speed clears duty and enable only.
  function void set_motor(int m, logic [6:0] spd, logic fwd_req);
    int pct;
    int lo;
    speed_now[m] = spd;
    ahead[m]     = fwd_req;
    if (spd == 0) begin
      duty_now[m] = '0;
      run_now[m]  = 1'b0;
    end else begin
      pct         = (min_pct > PCT_MAX) ? int'(PCT_MAX) : int'(min_pct);
      lo          = int'(FULL_DUTY) * pct / int'(PCT_MAX);
      duty_now[m] = 8'(lo + int'(spd) * (int'(FULL_DUTY) - lo) / int'(PCT_MAX));
      rev_pin[m]  = ~fwd_req;
      run_now[m]  = 1'b1;
    end
  endfunction

  // Advances the model by one accepted event and queues the state it shows.
  function void log_event(item_t it);
    result_t    r;
    logic       good;
    logic       bad_id;
    logic [6:0] spd;
    int         m;
    good   = (it.motor_id == ID_MOTOR1) || (it.motor_id == ID_MOTOR2);
    m      = (it.motor_id == ID_MOTOR2) ? 1 : 0;
    bad_id = 1'b0;
    case (it.func)
      FUNC_SET: begin
        if (!good) begin
          bad_id = 1'b1;
        end else begin
          spd = (it.speed_percent > 8'(PCT_MAX)) ? PCT_MAX : it.speed_percent[6:0];
          set_motor(m, spd, it.forward);
        end
      end
      FUNC_STOP: begin
        if (it.motor_id == ID_BOTH) begin
          set_motor(0, '0, ahead[0]);
          set_motor(1, '0, ahead[1]);
        end else if (good) begin
          set_motor(m, '0, ahead[m]);
        end else begin
          bad_id = 1'b1;
        end
      end
      FUNC_ESTOP: begin
        for (int k = 0; k < 2; k++) begin
          speed_now[k] = '0;
          duty_now[k]  = '0;
          run_now[k]   = 1'b0;
        end
      end
      FUNC_PULSE: begin
        if (good) pulse_cnt[m] = pulse_cnt[m] + 32'd1;
        else bad_id = 1'b1;
      end
      FUNC_TICK: begin
        if (ms_count != ELAPSED_MAX) ms_count = ms_count + 16'd1;
        if (ms_count >= period) begin
          for (int k = 0; k < 2; k++) begin
            rate_now[k]   = pulse_cnt[k] - pulse_mark[k];
            pulse_mark[k] = pulse_cnt[k];
          end
          ms_count = '0;
        end
      end
      default: begin
      end
    endcase
    r.m1_duty    = duty_now[0];
    r.m1_run     = run_now[0];
    r.m1_reverse = rev_pin[0];
    r.m1_speed   = speed_now[0];
    r.m2_duty    = duty_now[1];
    r.m2_run     = run_now[1];
    r.m2_reverse = rev_pin[1];
    r.m2_speed   = speed_now[1];
    r.m1_rate    = rate_now[0];
    r.m2_rate    = rate_now[1];
    r.status     = bad_id;
    awaited_states.push_back(r);
  endfunction

  function void match_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      errors++;
    end
  endfunction

  function void check_state(logic [103:0] raw);
    result_t got;
    result_t want;
    got = result_t'(raw[98:0]);
    if (awaited_states.size() == 0) begin
      $display("%0t: unexpected result, expected nothing, actual %h", $time, raw);
      errors++;
      return;
    end
    want = awaited_states.pop_front();
    match_field("m1_duty", want.m1_duty, got.m1_duty);
    match_field("m1_run", want.m1_run, got.m1_run);
    match_field("m1_reverse", want.m1_reverse, got.m1_reverse);
    match_field("m1_speed", want.m1_speed, got.m1_speed);
    match_field("m2_duty", want.m2_duty, got.m2_duty);
    match_field("m2_run", want.m2_run, got.m2_run);
    match_field("m2_reverse", want.m2_reverse, got.m2_reverse);
    match_field("m2_speed", want.m2_speed, got.m2_speed);
    match_field("m1_rate", want.m1_rate, got.m1_rate);
    match_field("m2_rate", want.m2_rate, got.m2_rate);
    match_field("status", want.status, got.status);
    match_field("padding", '0, raw[103:99]);
  endfunction

  function int outstanding();
    return awaited_states.size();
  endfunction
endclass

module tb_top;

  // Function codes the block leaves unused, and the motor id that is never valid.
  localparam logic [2:0] FUNC_RSVD_LO = 3'd5;
  localparam logic [2:0] FUNC_RSVD_HI = 3'd7;
  localparam logic [1:0] ID_BAD       = 2'd3;

  localparam int PHASES       = 6;
  localparam int PHASE_ITEMS  = 213;
  // The result side stops once for a long stretch after this many results.
  localparam int HOLD_AT      = 400;
  localparam int HOLD_CYCLES  = 150;
  // Four pipeline stages, with margin so that any stray result is caught.
  localparam int DRAIN_CYCLES = 12;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [15:0]  in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [103:0] out_tdata;
  logic         cfg_we = 1'b0;
  logic         cfg_addr = CFG_MIN_DUTY;
  logic [15:0]  cfg_wdata = '0;

  // When set, neither side inserts idle cycles.
  logic         steady = 1'b0;

  motor_board board = new();

  dual_motor_drive_with_pulse_rate_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Both monitors sample at the rising edge, before any driver update of that
  // edge lands, so each transaction is seen exactly as the block saw it.
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) board.log_event(item_t'(in_tdata[13:0]));
    if (rst_n && out_tvalid && out_tready) board.check_state(out_tdata);
  end

  function automatic item_t cmd(logic [2:0] f, logic [1:0] id, logic [7:0] spd, logic fw);
    item_t it;
    it.func          = f;
    it.motor_id      = id;
    it.speed_percent = spd;
    it.forward       = fw;
    return it;
  endfunction

  // Speeds lean to the interesting spots: zero, the clamp and the full range.
  function automatic logic [7:0] pick_speed();
    case ($urandom_range(0, 7))
      0: return 8'd0;
      1: return 8'($urandom_range(101, 255));
      2: return 8'(PCT_MAX);
      default: return 8'($urandom_range(1, 99));
    endcase
  endfunction

  // Mostly well-formed commands on valid motors, with pulses and ticks often
  // enough that rate samples come regularly; a small share is pure noise.
  function automatic item_t rand_event();
    item_t it;
    int    roll;
    roll             = $urandom_range(0, 99);
    it.motor_id      = 2'($urandom_range(ID_MOTOR1, ID_MOTOR2));
    it.speed_percent = pick_speed();
    it.forward       = 1'($urandom_range(0, 1));
    if (roll < 25) begin
      it.func = FUNC_SET;
    end else if (roll < 35) begin
      it.func = FUNC_STOP;
      if ($urandom_range(0, 3) == 0) it.motor_id = ID_BOTH;
    end else if (roll < 38) begin
      it.func = FUNC_ESTOP;
    end else if (roll < 68) begin
      it.func = FUNC_PULSE;
    end else if (roll < 93) begin
      it.func = FUNC_TICK;
    end else begin
      it.func     = 3'($urandom_range(0, 7));
      it.motor_id = 2'($urandom_range(0, 3));
    end
    return it;
  endfunction

  // Offers one event after a random gap and returns at the edge that takes it.
  // Valid stays high into the next call, so back-to-back events need no gap.
  task automatic send(item_t it);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {2'b00, it};
    do @(posedge clk); while (!in_tready);
  endtask

  // Stops offering and waits until every predicted result has come back.
  task automatic settle();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (board.outstanding() != 0);
  endtask

  // Writes both registers on consecutive edges while the block is idle.
  task automatic load_config(logic [6:0] min_pct, logic [15:0] period);
    cfg_we    <= 1'b1;
    cfg_addr  <= CFG_MIN_DUTY;
    cfg_wdata <= {9'd0, min_pct};
    @(posedge clk);
    board.write_reg(CFG_MIN_DUTY, {9'd0, min_pct});
    cfg_addr  <= CFG_PERIOD;
    cfg_wdata <= period;
    @(posedge clk);
    board.write_reg(CFG_PERIOD, period);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Result side: a random stall before each transaction, none while steady is
  // set, and one long hold-off so the pipeline fills and in_tready drops.
  initial begin
    int stall;
    int taken;
    taken = 0;
    do @(posedge clk); while (!rst_n);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 11);
      if (taken == HOLD_AT) stall = HOLD_CYCLES;
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      taken++;
    end
  end

  initial begin
    logic [6:0]  min_pct;
    logic [15:0] period;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. The first commands run with the reset configuration so
    // that the default minimum duty shows in the duty of every nonzero set on a valid motor.
    send(cmd(FUNC_SET, ID_MOTOR1, 8'd0, 1'b1));
    send(cmd(FUNC_SET, ID_MOTOR1, 8'd100, 1'b0));
    send(cmd(FUNC_SET, ID_MOTOR2, 8'd255, 1'b1));
    send(cmd(FUNC_SET, ID_MOTOR2, 8'd1, 1'b0));
    // A set on id 0 or id 3 must change nothing and flag the id.
    send(cmd(FUNC_SET, ID_BOTH, 8'd50, 1'b0));
    send(cmd(FUNC_SET, ID_BAD, 8'd50, 1'b0));
    // Stop keeps the stored direction, and a zero-speed set leaves the pin.
    send(cmd(FUNC_STOP, ID_MOTOR1, 8'd0, 1'b0));
    send(cmd(FUNC_SET, ID_MOTOR1, 8'd0, 1'b1));
    send(cmd(FUNC_SET, ID_MOTOR1, 8'd37, 1'b1));
    send(cmd(FUNC_STOP, ID_BAD, 8'd0, 1'b0));
    send(cmd(FUNC_STOP, ID_BOTH, 8'd0, 1'b0));
    send(cmd(FUNC_SET, ID_MOTOR1, 8'd60, 1'b0));
    send(cmd(FUNC_SET, ID_MOTOR2, 8'd80, 1'b1));
    // Emergency stop ignores the id and keeps both directions.
    send(cmd(FUNC_ESTOP, ID_BAD, 8'hFF, 1'b1));
    for (int f = FUNC_RSVD_LO; f <= FUNC_RSVD_HI; f++) begin
      send(cmd(3'(f), ID_MOTOR1, 8'h55, 1'b1));
    end

    // A short sample period lets the directed pulses show up as rates.
    settle();
    load_config(MIN_DUTY_RST, 16'd2);
    send(cmd(FUNC_PULSE, ID_MOTOR1, 8'd0, 1'b0));
    send(cmd(FUNC_PULSE, ID_MOTOR1, 8'd0, 1'b0));
    send(cmd(FUNC_PULSE, ID_MOTOR2, 8'd0, 1'b0));
    send(cmd(FUNC_PULSE, ID_BOTH, 8'd0, 1'b0));
    send(cmd(FUNC_PULSE, ID_BAD, 8'd0, 1'b0));
    send(cmd(FUNC_TICK, ID_MOTOR1, 8'd0, 1'b0));
    send(cmd(FUNC_TICK, ID_MOTOR2, 8'd0, 1'b0));

    // Random phases, each under its own configuration. The block is drained
    // before every write. Phase one uses a zero period, which samples on
    // every tick; phase four uses the longest period, so its ticks pile up
    // and the small period of the last phase samples on its first tick.
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin min_pct = 7'd0; period = 16'd1; end
        1: begin min_pct = 7'd100; period = 16'd0; end
        2: begin min_pct = 7'd127; period = 16'd3; end
        3: begin
          min_pct = 7'($urandom_range(0, 100));
          period  = 16'($urandom_range(1, 6));
        end
        4: begin min_pct = 7'($urandom_range(0, 127)); period = 16'hFFFF; end
        default: begin
          min_pct = 7'($urandom_range(0, 100));
          period  = 16'($urandom_range(2, 9));
        end
      endcase
      settle();
      load_config(min_pct, period);
      // Phase three runs without any idle cycles on either side.
      steady <= (p == 3);
      repeat (PHASE_ITEMS) send(rand_event());
    end

    steady <= 1'b0;
    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.errors == 0 && board.outstanding() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Hard stop far beyond the slowest correct run.
  initial begin
    #3000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
